### design/srufir_pkg.sv
// Shared types, constants and the coefficient table of the stereo upsampling FIR.
// No dependencies; every other file of the block imports this package.
package srufir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RING_DEPTH = 64;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int TAP_COUNT  = 39;
    localparam int TAP_W      = 6;
    localparam int LANE_COUNT = 8;
    localparam int LANE_W     = $clog2(LANE_COUNT);
    localparam int PAIR_COUNT = LANE_COUNT / 2;
    localparam int DRAIN_CYC  = 2;

    localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;

    typedef struct packed {
        logic             in_ready;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             pair_en;
        logic             load_out;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_sts;

    // Half-band set doubled and clamped to the signed 16-bit range.
    function automatic logic signed [SAMPLE_W-1:0] up_coef(input logic [TAP_W-1:0] k);
        case (k)
            6'd0:    return -16'sd2;
            6'd2:    return 16'sd4;
            6'd4:    return -16'sd20;
            6'd6:    return 16'sd70;
            6'd8:    return -16'sd206;
            6'd10:   return 16'sd532;
            6'd12:   return -16'sd1232;
            6'd14:   return 16'sd2664;
            6'd16:   return -16'sd5920;
            6'd18:   return 16'sd20492;
            6'd19:   return 16'sd32767;
            6'd20:   return 16'sd20492;
            6'd22:   return -16'sd5920;
            6'd24:   return 16'sd2664;
            6'd26:   return -16'sd1232;
            6'd28:   return 16'sd532;
            6'd30:   return -16'sd206;
            6'd32:   return 16'sd70;
            6'd34:   return -16'sd20;
            6'd36:   return 16'sd4;
            6'd38:   return -16'sd2;
            default: return 16'sd0;
        endcase
    endfunction

endpackage

### design/srufir_in_if.sv
// Input channel: one stereo sample pair per word, valid/ready handshake.
// Depends on srufir_pkg for the sample width.
interface srufir_in_if import srufir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

### design/srufir_out_if.sv
// Output channel: one filtered stereo pair per word, valid/ready handshake.
// Depends on srufir_pkg for the sample width.
interface srufir_out_if import srufir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

### design/srufir_ctrl.sv
// Sequencer of the FIR: walks the taps, drains the pipeline and runs the lane sum.
// Depends on srufir_pkg for the command and status structs.
module srufir_ctrl import srufir_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_SUM1  = 5'b01000,
        S_SUM2  = 5'b10000
    } t_state;

    localparam logic [TAP_W-1:0] LAST_TAP   = TAP_W'(TAP_COUNT - 1);
    localparam logic [TAP_W-1:0] LAST_DRAIN = TAP_W'(DRAIN_CYC - 1);

    t_state           r_state, n_state;
    logic [TAP_W-1:0] r_tap, n_tap;

    always_comb begin
        n_state        = r_state;
        n_tap          = r_tap;
        o_cmd.in_ready = 1'b0;
        o_cmd.issue    = 1'b0;
        o_cmd.tap      = r_tap;
        o_cmd.pair_en  = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = S_RUN;
                    n_tap   = '0;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (r_tap == LAST_TAP) begin
                    n_state = S_DRAIN;
                    n_tap   = '0;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_tap == LAST_DRAIN) begin
                    n_state = S_SUM1;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_SUM1: begin
                o_cmd.pair_en = 1'b1;
                n_state       = S_SUM2;
            end
            S_SUM2: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_sts.in_valid |=> (r_state == S_RUN) && (r_tap == '0))
        else $error("accepted word did not start the tap walk at tap zero");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_tap <= LAST_TAP))
        else $error("tap index ran past the last tap");

endmodule

### design/srufir_dp.sv
// Datapath of the FIR: delay rings, shared multiply per channel, lanes and output register.
// Depends on srufir_pkg, srufir_in_if and srufir_out_if.
module srufir_dp import srufir_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    srufir_in_if.sink     i_in,
    srufir_out_if.source  o_out
);

    localparam logic [ADDR_W-1:0] START_OFS = ADDR_W'(TAP_COUNT);

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [18:0] v);
        if (v > 19'(S16_MAX)) return S16_MAX;
        if (v < 19'(S16_MIN)) return S16_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    // Rounded doubling multiply-high of a 32-bit product.
    function automatic logic signed [SAMPLE_W-1:0] rnd_mulh(input logic signed [31:0] p);
        logic signed [33:0] v;
        v = (34'(p) <<< 1) + 34'sd32768;
        return sat16(19'($signed(v[33:16])));
    endfunction

    logic signed [SAMPLE_W-1:0] r_ring_l [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] r_ring_r [RING_DEPTH];
    logic [RING_DEPTH-1:0]      r_valid;
    logic [ADDR_W-1:0]          r_wp;

    logic signed [SAMPLE_W-1:0] r_rd_l, r_rd_r;
    logic                       r_rv;
    logic                       r_v1, r_v2;
    logic [TAP_W-1:0]           r_k1;
    logic [LANE_W-1:0]          r_k2;
    logic signed [31:0]         r_prod_l, r_prod_r;
    logic signed [SAMPLE_W-1:0] r_lane_l [LANE_COUNT];
    logic signed [SAMPLE_W-1:0] r_lane_r [LANE_COUNT];
    logic signed [SAMPLE_W:0]   r_pair_l [PAIR_COUNT];
    logic signed [SAMPLE_W:0]   r_pair_r [PAIR_COUNT];
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r;

    logic                       in_fire;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [SAMPLE_W-1:0] s_l, s_r, coef;
    logic signed [SAMPLE_W-1:0] p_l, p_r;
    logic signed [18:0]         total_l, total_r;

    assign in_fire    = i_cmd.in_ready && i_in.valid;
    assign i_in.ready = i_cmd.in_ready;
    assign rd_addr    = r_wp + ADDR_W'(i_cmd.tap) - START_OFS;

    assign s_l  = r_rv ? r_rd_l : '0;
    assign s_r  = r_rv ? r_rd_r : '0;
    assign coef = up_coef(r_k1);
    assign p_l  = rnd_mulh(r_prod_l);
    assign p_r  = rnd_mulh(r_prod_r);

    always_comb begin
        total_l = '0;
        total_r = '0;
        for (int j = 0; j < PAIR_COUNT; j++) begin
            total_l = total_l + 19'(r_pair_l[j]);
            total_r = total_r + 19'(r_pair_r[j]);
        end
    end

    // Ring memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ring_l[r_wp] <= i_in.in_left;
            r_ring_r[r_wp] <= i_in.in_right;
        end
        r_rd_l <= r_ring_l[rd_addr];
        r_rd_r <= r_ring_r[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_valid   <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_fire) begin
                r_wp          <= r_wp + 1'b1;
                r_valid[r_wp] <= 1'b1;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rv     <= r_valid[rd_addr];
        r_k1     <= i_cmd.tap;
        r_k2     <= r_k1[LANE_W-1:0];
        r_prod_l <= 32'(s_l) * 32'(coef);
        r_prod_r <= 32'(s_r) * 32'(coef);
        if (in_fire) begin
            for (int j = 0; j < LANE_COUNT; j++) begin
                r_lane_l[j] <= '0;
                r_lane_r[j] <= '0;
            end
        end else if (r_v2) begin
            r_lane_l[r_k2] <= sat16(19'(r_lane_l[r_k2]) + 19'(p_l));
            r_lane_r[r_k2] <= sat16(19'(r_lane_r[r_k2]) + 19'(p_r));
        end
        if (i_cmd.pair_en) begin
            for (int j = 0; j < PAIR_COUNT; j++) begin
                r_pair_l[j] <= 17'(r_lane_l[2*j]) + 17'(r_lane_l[2*j+1]);
                r_pair_r[j] <= 17'(r_lane_r[2*j]) + 17'(r_lane_r[2*j+1]);
            end
        end
        if (i_cmd.load_out) begin
            r_out_l <= sat16(total_l);
            r_out_r <= sat16(total_r);
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.out_left  = r_out_l;
    assign o_out.out_right = r_out_r;

    assign o_sts.in_valid = i_in.valid;
    assign o_sts.out_free = !r_out_vld || o_out.ready;

    a_no_accept_mid_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 || r_v2 |-> !i_cmd.in_ready)
        else $error("input taken while taps were still in the pipeline");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_vld || o_out.ready))
        else $error("output register overwritten before its word was taken");

endmodule

### design/stereo_reverb_upsample_fir_top.sv
// Top level of the stereo half-band upsampling FIR.
// Depends on srufir_pkg, srufir_in_if, srufir_out_if, srufir_ctrl and srufir_dp.
//
// Usage:
//   i_in carries one stereo sample pair per word. Each accepted word is written
//   into a 64-entry delay ring per channel, then the 39 newest samples of each
//   channel are filtered by the half-band coefficients, one tap per cycle on a
//   multiplier per channel, into eight saturating lanes that are summed at the end.
//   o_out carries the filtered pair, one word per accepted input word.
// Sequence:
//   A word accepted on i_in is filtered in order by the tap walk, a drain of the
//   pipeline (ring read, product and lane registers) and the lane summation (pair
//   sums, then the total into the output register). No new word is taken until
//   the result of the previous one has been loaded into the output register.
//   i_in.ready is high only while the block waits for a new word.
// Reset:
//   i_rst_n is synchronous and active low. It empties the rings (per-entry valid
//   bits make unwritten entries read as zero), clears the write pointer and drops
//   o_out.valid. No clearing pass is needed, so the block is ready right after reset.
// Stalls:
//   The result sits in an output register, so a new word is accepted while it
//   waits. If the previous result is still not taken when the next one is done,
//   the block holds the new result internally and stops accepting until it moves.
module stereo_reverb_upsample_fir_top import srufir_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srufir_in_if.sink    i_in,
    srufir_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: owns the tap counter and the phases of one filter run.
    srufir_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: rings, multiplies, lanes and the output register.
    srufir_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
